### sv/ewis_pkg.sv
// ============================================================================
// ewis_pkg
// Shared widths, reset values and types for the ECG window integrator and
// smoother.
// ============================================================================
package ewis_pkg;

    // Fixed port widths.
    localparam int SAMPLE_PORT_W = 32;
    localparam int LEVEL_W       = 32;
    localparam int CLAMP_W       = 31;

    // Reset value of the clamp limit register.
    localparam logic [CLAMP_W-1:0] CLAMP_RESET = 31'd45600;

    // Quotient bits resolved per divider pipeline stage.
    localparam int DIV_STEPS = 8;

    // Smoother fill status that travels with each word.
    typedef struct packed {
        logic full;      // smoother window already full: drop the oldest entry
        logic use_mean;  // this word completes or follows a full window
    } ewis_fill_t;

endpackage

### sv/ewis_div.sv
// ============================================================================
// ewis_div
// Pipelined signed division by a constant, truncating toward zero. The
// magnitude is divided by restoring long division, DIV_STEPS quotient bits
// per stage, with a narrow remainder. A sideband field travels alongside.
// ============================================================================
module ewis_div #(
    parameter int DIVISOR = 45,
    parameter int DATA_W  = 39,
    parameter int SIDE_W  = 2
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic                     in_valid,
    input  logic signed [DATA_W-1:0] in_num,
    input  logic [SIDE_W-1:0]        in_side,
    output logic                     out_valid,
    output logic signed [DATA_W-1:0] out_quot,
    output logic [SIDE_W-1:0]        out_side
);
    import ewis_pkg::*;

    localparam int NST = (DATA_W + DIV_STEPS - 1) / DIV_STEPS;
    localparam int PW  = NST * DIV_STEPS;
    localparam int RW  = $clog2(DIVISOR) + 1;
    localparam logic [RW-1:0] DIV_C = RW'(DIVISOR);

    logic                     in_valid_reg;
    logic signed [DATA_W-1:0] in_num_reg;
    logic [SIDE_W-1:0]        in_side_reg;

    logic [NST:0]             v_reg;
    logic [NST:0]             neg_reg;
    logic [PW-1:0]            work_reg [NST+1];
    logic [RW-1:0]            rem_reg  [NST+1];
    logic [SIDE_W-1:0]        side_reg [NST+1];

    logic                     out_valid_reg;
    logic signed [DATA_W-1:0] out_quot_reg;
    logic [SIDE_W-1:0]        out_side_reg;

    logic [DATA_W-1:0]        mag_next;
    logic [PW-1:0]            work_next [NST];
    logic [RW-1:0]            rem_next  [NST];
    logic [DATA_W-1:0]        quot_next;

    // Magnitude of the registered dividend.
    assign mag_next = in_num_reg[DATA_W-1] ? DATA_W'(-in_num_reg) : DATA_W'(in_num_reg);

    // Long division steps: shift one dividend bit into the remainder,
    // subtract the divisor when it fits and record a quotient bit.
    always_comb
    begin : div_steps
        logic [RW-1:0] r;
        logic [PW-1:0] w;
        r = '0;
        w = '0;
        for (int k = 0; k < NST; k++)
        begin
            r = rem_reg[k];
            w = work_reg[k];
            for (int j = 0; j < DIV_STEPS; j++)
            begin
                r = {r[RW-2:0], w[PW-1]};
                w = {w[PW-2:0], 1'b0};
                if (r >= DIV_C)
                begin
                    r    = r - DIV_C;
                    w[0] = 1'b1;
                end
            end
            rem_next[k]  = r;
            work_next[k] = w;
        end
    end

    // Restore the sign of the quotient.
    assign quot_next = neg_reg[NST] ? DATA_W'(-work_reg[NST][DATA_W-1:0])
                                    : work_reg[NST][DATA_W-1:0];

    // Valid bits of the pipeline.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            v_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            in_valid_reg  <= in_valid;
            v_reg         <= {v_reg[NST-1:0], in_valid_reg};
            out_valid_reg <= v_reg[NST];
        end
    end

    // Data path of the pipeline.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            in_num_reg   <= in_num;
            in_side_reg  <= in_side;
            work_reg[0]  <= PW'(mag_next);
            rem_reg[0]   <= '0;
            neg_reg[0]   <= in_num_reg[DATA_W-1];
            side_reg[0]  <= in_side_reg;
            for (int k = 0; k < NST; k++)
            begin
                work_reg[k+1] <= work_next[k];
                rem_reg[k+1]  <= rem_next[k];
                neg_reg[k+1]  <= neg_reg[k];
                side_reg[k+1] <= side_reg[k];
            end
            out_quot_reg <= quot_next;
            out_side_reg <= side_reg[NST];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_quot  = out_quot_reg;
    assign out_side  = out_side_reg;

endmodule

### sv/ecg_window_integrator_smoother_unit.sv
// ============================================================================
// ecg_window_integrator_smoother_unit
// Two-stage ECG smoother: a moving-window integrator over the last WINDOW_LEN
// samples, divided by the window length and clamped from above at
// clamp_limit, followed by a moving mean over the last WINDOW_LEN integrator
// values. While the second window fills, level is the clamped integrator
// value; from the word that fills it on, level is the mean. The block takes
// one sample word per clock while the output buffer has room and returns one
// level word per sample. The two constant dividers resolve eight quotient
// bits per stage. Both windows sit in single-port rings whose oldest entry is
// read into a register ahead of the running sum update. A two-word output
// buffer lets the block keep accepting samples while a finished level waits
// to be taken. Only the low SAMPLE_WIDTH bits of sample are used,
// sign-extended. The user must write clamp_limit through cfg_we and
// cfg_wdata only while the block is idle; the block itself does not enforce
// this.
// ============================================================================
module ecg_window_integrator_smoother_unit #(
    parameter int WINDOW_LEN   = 45,
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     sample_valid,
    output logic                                     sample_ready,
    input  logic signed [ewis_pkg::SAMPLE_PORT_W-1:0] sample,
    output logic                                     level_valid,
    input  logic                                     level_ready,
    output logic signed [ewis_pkg::LEVEL_W-1:0]       level,
    input  logic                                     cfg_we,
    input  logic [ewis_pkg::CLAMP_W-1:0]              cfg_wdata
);
    import ewis_pkg::*;

    localparam int SW    = SAMPLE_WIDTH;
    localparam int PTR_W = $clog2(WINDOW_LEN);
    localparam int CNT_W = $clog2(WINDOW_LEN + 1);
    localparam int TOT_W = SW + $clog2(WINDOW_LEN) + 1;
    localparam int CMP_W = CLAMP_W + 1;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW_LEN - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(WINDOW_LEN);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WINDOW_LEN - 1);

    // Flow control and configuration.
    logic                     adv;
    logic                     accept;
    logic [CLAMP_W-1:0]       clamp_reg;

    // Integrator ring and input stage.
    logic [SW-1:0]            raw_mem [WINDOW_LEN];
    logic [WINDOW_LEN-1:0]    raw_vld_reg;
    logic signed [SW-1:0]     raw_rd_reg;
    logic                     raw_rd_vld_reg;
    logic [PTR_W-1:0]         raw_ptr_reg;
    logic [PTR_W-1:0]         raw_ptr_next;
    logic [CNT_W-1:0]         fill_cnt_reg;
    logic [CNT_W-1:0]         fill_cnt_next;
    ewis_fill_t               fill_cur;
    logic signed [SW-1:0]     x_in;
    logic                     a_valid_reg;
    logic signed [SW-1:0]     a_x_reg;
    ewis_fill_t               a_fill_reg;
    logic signed [SW-1:0]     raw_old;
    logic signed [TOT_W-1:0]  raw_total_reg;
    logic signed [TOT_W-1:0]  raw_total_next;

    // First divider and clamp stage.
    logic                     d1_valid;
    logic signed [TOT_W-1:0]  d1_quot;
    logic [1:0]               d1_side;
    logic signed [SW-1:0]     q1;
    logic signed [CMP_W-1:0]  q1_ext;
    logic signed [CMP_W-1:0]  lim_ext;
    logic signed [SW-1:0]     stage1_next;
    logic                     c_valid_reg;
    logic signed [SW-1:0]     c_val_reg;
    ewis_fill_t               c_fill_reg;

    // Smoother ring and sum.
    logic [SW-1:0]            smooth_mem [WINDOW_LEN];
    logic signed [SW-1:0]     smooth_rd_reg;
    logic [PTR_W-1:0]         smooth_ptr_reg;
    logic [PTR_W-1:0]         smooth_ptr_next;
    logic                     d_valid_reg;
    logic signed [SW-1:0]     d_val_reg;
    ewis_fill_t               d_fill_reg;
    logic signed [SW-1:0]     smooth_old;
    logic signed [TOT_W-1:0]  smooth_total_reg;
    logic signed [TOT_W-1:0]  smooth_total_next;

    // Second divider and output buffer.
    logic                     d2_valid;
    logic signed [TOT_W-1:0]  d2_quot;
    logic [SW:0]              d2_side;
    logic signed [SW-1:0]     level_sel;
    logic                     push;
    logic signed [LEVEL_W-1:0] push_data;
    logic                     take;
    logic                     load_from_skid;
    logic                     load_from_push;
    logic                     load_skid;
    logic                     level_valid_reg;
    logic signed [LEVEL_W-1:0] level_reg;
    logic                     skid_valid_reg;
    logic signed [LEVEL_W-1:0] skid_data_reg;

    // The pipeline moves as a whole while the output buffer has room.
    assign adv          = !skid_valid_reg;
    assign sample_ready = adv;
    assign accept       = sample_valid && adv;

    // Input conditioning, ring pointer and fill tracking.
    assign x_in              = sample[SW-1:0];
    assign raw_ptr_next      = (raw_ptr_reg == PTR_LAST) ? '0 : raw_ptr_reg + 1'b1;
    assign smooth_ptr_next   = (smooth_ptr_reg == PTR_LAST) ? '0 : smooth_ptr_reg + 1'b1;
    assign fill_cnt_next     = (fill_cnt_reg == CNT_FULL) ? fill_cnt_reg : fill_cnt_reg + 1'b1;
    assign fill_cur.full     = (fill_cnt_reg == CNT_FULL);
    assign fill_cur.use_mean = (fill_cnt_reg >= CNT_LAST);

    // Integrator sum: drop the oldest sample, add the new one. Entries
    // never written since reset read as zero.
    assign raw_old        = raw_rd_vld_reg ? raw_rd_reg : '0;
    assign raw_total_next = raw_total_reg - TOT_W'(raw_old) + TOT_W'(a_x_reg);

    // Upper clamp of the integrator value.
    assign q1          = d1_quot[SW-1:0];
    assign q1_ext      = CMP_W'(q1);
    assign lim_ext     = signed'({1'b0, clamp_reg});
    assign stage1_next = (q1_ext > lim_ext) ? lim_ext[SW-1:0] : q1;

    // Smoother sum: the oldest entry leaves only once the window is full.
    assign smooth_old        = d_fill_reg.full ? smooth_rd_reg : '0;
    assign smooth_total_next = smooth_total_reg - TOT_W'(smooth_old) + TOT_W'(d_val_reg);

    // Level selection: integrator value while filling, mean afterwards.
    assign level_sel = d2_side[SW] ? d2_quot[SW-1:0] : d2_side[SW-1:0];
    assign push      = adv && d2_valid;
    assign push_data = LEVEL_W'(level_sel);

    // Output buffer control.
    assign take           = level_valid_reg && level_ready;
    assign load_from_skid = (!level_valid_reg || take) && skid_valid_reg;
    assign load_from_push = (!level_valid_reg || take) && !skid_valid_reg && push;
    assign load_skid      = level_valid_reg && !take && push;

    // Control state and running sums.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clamp_reg        <= CLAMP_RESET;
            raw_vld_reg      <= '0;
            raw_rd_vld_reg   <= 1'b0;
            raw_ptr_reg      <= '0;
            fill_cnt_reg     <= '0;
            a_valid_reg      <= 1'b0;
            raw_total_reg    <= '0;
            c_valid_reg      <= 1'b0;
            smooth_ptr_reg   <= '0;
            d_valid_reg      <= 1'b0;
            smooth_total_reg <= '0;
            level_valid_reg  <= 1'b0;
            skid_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                clamp_reg <= cfg_wdata;
            end
            if (accept)
            begin
                raw_vld_reg[raw_ptr_reg] <= 1'b1;
                raw_rd_vld_reg           <= raw_vld_reg[raw_ptr_reg];
                raw_ptr_reg              <= raw_ptr_next;
                fill_cnt_reg             <= fill_cnt_next;
            end
            if (adv)
            begin
                a_valid_reg <= accept;
                c_valid_reg <= d1_valid;
                d_valid_reg <= c_valid_reg;
                if (a_valid_reg)
                begin
                    raw_total_reg <= raw_total_next;
                end
                if (c_valid_reg)
                begin
                    smooth_ptr_reg <= smooth_ptr_next;
                end
                if (d_valid_reg)
                begin
                    smooth_total_reg <= smooth_total_next;
                end
            end
            if (load_from_skid)
            begin
                level_valid_reg <= 1'b1;
                skid_valid_reg  <= 1'b0;
            end
            else if (!level_valid_reg || take)
            begin
                level_valid_reg <= push;
            end
            else if (load_skid)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    // Pipeline and output data registers.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_x_reg    <= x_in;
            a_fill_reg <= fill_cur;
            c_val_reg  <= stage1_next;
            c_fill_reg <= ewis_fill_t'(d1_side);
            d_val_reg  <= c_val_reg;
            d_fill_reg <= c_fill_reg;
        end
        if (load_from_skid)
        begin
            level_reg <= skid_data_reg;
        end
        else if (load_from_push)
        begin
            level_reg <= push_data;
        end
        if (load_skid)
        begin
            skid_data_reg <= push_data;
        end
    end

    // Integrator ring: the oldest sample is read as the new one replaces it.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            raw_rd_reg           <= raw_mem[raw_ptr_reg];
            raw_mem[raw_ptr_reg] <= x_in;
        end
    end

    // Smoother ring: the oldest value is read as the new one replaces it.
    always_ff @(posedge clk)
    begin
        if (adv && c_valid_reg)
        begin
            smooth_rd_reg              <= smooth_mem[smooth_ptr_reg];
            smooth_mem[smooth_ptr_reg] <= c_val_reg;
        end
    end

    // Integrator sum divided by the window length.
    ewis_div #(
        .DIVISOR (WINDOW_LEN),
        .DATA_W  (TOT_W),
        .SIDE_W  (2)
    ) u_div_raw (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (a_valid_reg),
        .in_num    (raw_total_next),
        .in_side   (a_fill_reg),
        .out_valid (d1_valid),
        .out_quot  (d1_quot),
        .out_side  (d1_side)
    );

    // Smoother sum divided by the window length.
    ewis_div #(
        .DIVISOR (WINDOW_LEN),
        .DATA_W  (TOT_W),
        .SIDE_W  (SW + 1)
    ) u_div_smooth (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (d_valid_reg),
        .in_num    (smooth_total_next),
        .in_side   ({d_fill_reg.use_mean, d_val_reg}),
        .out_valid (d2_valid),
        .out_quot  (d2_quot),
        .out_side  (d2_side)
    );

    assign level_valid = level_valid_reg;
    assign level       = level_reg;

endmodule

### tb/sv/ecg_window_integrator_smoother_unit_test.sv
`timescale 1ns / 1ps
// ============================================================================
// ecg_window_integrator_smoother_unit_test
// Self-checking bench for the two-stage ECG smoother. A short directed table
// covers the field extremes, negative integrator values and the upper clamp.
// Random phases follow, each under its own clamp limit, and they include the
// limit extremes. Every accepted sample word runs through a local model of the
// integrator and the moving mean, and every level word is checked in order.
// Both sides idle at random. One long receiver hold-off fills the block, and
// one sender pause lets it drain completely.
// ============================================================================
module ecg_window_integrator_smoother_unit_test;
    import ewis_pkg::*;

    localparam int WIN_LEN            = 45;
    localparam int SUM_W              = 38;
    localparam int DIRECTED_N         = 24;
    localparam int PHASE_N            = 6;
    localparam int PHASE_WORDS        = 215;
    localparam int MID_WORD           = 100;
    localparam int PAUSE_PHASE        = 1;
    localparam int HOLD_PHASE         = 3;
    localparam int RANDOM_CLAMP_PHASE = 3;
    localparam int HOLD_CYCLES        = 300;
    localparam int SETTLE_CYCLES      = 40;
    localparam int STALL_LIMIT        = 2000;
    localparam int MAX_PRINTS         = 40;

    localparam logic signed [SAMPLE_PORT_W-1:0] SAMPLE_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [SAMPLE_PORT_W-1:0] SAMPLE_MIN = 32'sh8000_0000;
    localparam logic [CLAMP_W-1:0]              CLAMP_MAX  = 31'h7FFF_FFFF;

    // One row of the directed table; want is used only where typed is set.
    typedef struct {
        logic signed [SAMPLE_PORT_W-1:0] value;
        bit                              typed;
        logic signed [LEVEL_W-1:0]       want;
    } stim_row_t;

    // Typed results assume the rows before them, from cleared windows at the reset clamp.
    stim_row_t directed_rows [DIRECTED_N] = '{
        '{32'sd4500,     1'b1, 32'sd100},
        '{-32'sd4545,    1'b1, -32'sd1},
        '{SAMPLE_MAX,    1'b1, 32'sd45600},
        '{SAMPLE_MIN,    1'b1, -32'sd1},
        '{-32'sd44,      1'b1, -32'sd2},
        '{32'sd0,        1'b0, 32'sd0},
        '{SAMPLE_MAX,    1'b0, 32'sd0},
        '{SAMPLE_MAX,    1'b0, 32'sd0},
        '{SAMPLE_MAX,    1'b0, 32'sd0},
        '{SAMPLE_MAX,    1'b0, 32'sd0},
        '{SAMPLE_MAX,    1'b0, 32'sd0},
        '{SAMPLE_MAX,    1'b0, 32'sd0},
        '{SAMPLE_MIN,    1'b0, 32'sd0},
        '{SAMPLE_MIN,    1'b0, 32'sd0},
        '{SAMPLE_MIN,    1'b0, 32'sd0},
        '{SAMPLE_MIN,    1'b0, 32'sd0},
        '{SAMPLE_MIN,    1'b0, 32'sd0},
        '{SAMPLE_MIN,    1'b0, 32'sd0},
        '{32'sd1,        1'b0, 32'sd0},
        '{-32'sd1,       1'b0, 32'sd0},
        '{32'sd2052000,  1'b0, 32'sd0},
        '{32'sd2052045,  1'b0, 32'sd0},
        '{32'sh5555_5555, 1'b0, 32'sd0},
        '{32'shAAAA_AAAA, 1'b0, 32'sd0}
    };

    // Clamp limit per random phase; the random-clamp phase draws its own.
    localparam logic [CLAMP_W-1:0] PHASE_CLAMPS [PHASE_N] = '{
        CLAMP_MAX, 31'd0, CLAMP_RESET, CLAMP_RESET, 31'd1, CLAMP_MAX
    };
    localparam bit PHASE_IDLE_FREE [PHASE_N] = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            sample_valid;
    logic                            sample_ready;
    logic signed [SAMPLE_PORT_W-1:0] sample;
    logic                            level_valid;
    logic                            level_ready;
    logic signed [LEVEL_W-1:0]       level;
    logic                            cfg_we;
    logic [CLAMP_W-1:0]              cfg_wdata;

    // Local copy of the integrator and smoother state.
    logic signed [SAMPLE_PORT_W-1:0] raw_ring [WIN_LEN];
    logic signed [SUM_W-1:0]         raw_sum;
    int unsigned                     raw_head;
    logic signed [LEVEL_W-1:0]       mean_ring [WIN_LEN];
    logic signed [SUM_W-1:0]         mean_sum;
    int unsigned                     mean_head;
    int unsigned                     mean_fill;
    logic [CLAMP_W-1:0]              clamp_limit;

    logic signed [LEVEL_W-1:0]       expected_levels [$];

    bit                              no_idle;
    bit                              hold_request;
    int                              run_left;
    logic signed [SAMPLE_PORT_W-1:0] run_value;
    int                              samples_sent;
    int                              levels_checked;
    int                              full_words;
    int                              mismatch_count;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    ecg_window_integrator_smoother_unit #(
        .WINDOW_LEN   (WIN_LEN),
        .SAMPLE_WIDTH (SAMPLE_PORT_W)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .level_valid  (level_valid),
        .level_ready  (level_ready),
        .level        (level),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata)
    );

    // Advances the local state by one sample and returns the level it causes.
    function automatic logic signed [LEVEL_W-1:0] integrate_and_smooth(
        input logic signed [SAMPLE_PORT_W-1:0] x
    );
        logic signed [SUM_W-1:0]   quotient;
        logic signed [LEVEL_W-1:0] integ;
        logic signed [LEVEL_W-1:0] limit;

        // Stage one: running sum over the sample ring, then the upper clamp.
        raw_sum = raw_sum - raw_ring[raw_head] + x;
        raw_ring[raw_head] = x;
        raw_head = (raw_head == WIN_LEN - 1) ? 0 : raw_head + 1;
        quotient = raw_sum / WIN_LEN;
        integ = quotient[LEVEL_W-1:0];
        limit = $signed({1'b0, clamp_limit});
        if (integ > limit)
            integ = limit;

        // Stage two: the oldest entry leaves the sum only once the ring is full.
        if (mean_fill < WIN_LEN)
        begin
            mean_sum = mean_sum + integ;
            mean_fill++;
        end
        else
        begin
            mean_sum = mean_sum - mean_ring[mean_head] + integ;
        end
        mean_ring[mean_head] = integ;
        mean_head = (mean_head == WIN_LEN - 1) ? 0 : mean_head + 1;
        if (mean_fill < WIN_LEN)
            return integ;
        quotient = mean_sum / WIN_LEN;
        return quotient[LEVEL_W-1:0];
    endfunction

    // Random samples: ECG-like levels, small signed values, full-range
    // words, extremes, and now and then a run long enough to fill a window.
    function automatic logic signed [SAMPLE_PORT_W-1:0] draw_sample();
        int pick;

        if (run_left > 0)
        begin
            run_left--;
            return run_value;
        end
        pick = $urandom_range(0, 199);
        if (pick == 0)
        begin
            run_left = $urandom_range(45, 60);
            case ($urandom_range(0, 2))
                0:       run_value = SAMPLE_MAX;
                1:       run_value = SAMPLE_MIN;
                default: run_value = $urandom;
            endcase
            return run_value;
        end
        if (pick < 80)
            return $urandom_range(0, 100000);
        if (pick < 120)
            return $urandom;
        if (pick < 160)
            return $signed($urandom_range(0, 2000)) - 1000;
        case ($urandom_range(0, 4))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2:       return 32'sd0;
            3:       return -32'sd1;
            default: return 32'sd1;
        endcase
    endfunction

    task automatic report_mismatch(
        input string                     what,
        input logic signed [LEVEL_W-1:0] got,
        input logic signed [LEVEL_W-1:0] want
    );
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS)
            $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    // Compares one accepted level word with the oldest outstanding one.
    task automatic check_level(input logic signed [LEVEL_W-1:0] got);
        logic signed [LEVEL_W-1:0] want;

        levels_checked++;
        if (expected_levels.size() == 0)
        begin
            report_mismatch("level word with nothing outstanding", got, '0);
        end
        else
        begin
            want = expected_levels.pop_front();
            if (got !== want)
                report_mismatch("level mismatch", got, want);
        end
    endtask

    // Offers one sample word after a random gap and records its level.
    task automatic send_word(
        input logic signed [SAMPLE_PORT_W-1:0] value,
        input bit                              typed,
        input logic signed [LEVEL_W-1:0]       want
    );
        int                        gap;
        logic signed [LEVEL_W-1:0] predicted;

        gap = no_idle ? 0 : $urandom_range(0, 8);
        @(negedge clk);
        if (gap > 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        sample_valid <= 1'b1;
        sample       <= value;
        @(posedge clk);
        while (!sample_ready)
            @(posedge clk);
        predicted = integrate_and_smooth(value);
        expected_levels.push_back(typed ? want : predicted);
        samples_sent++;
        if (mean_fill == WIN_LEN)
            full_words++;
    endtask

    // Stops offering words and waits until every outstanding level is in.
    task automatic drain_levels();
        @(negedge clk);
        sample_valid <= 1'b0;
        while (expected_levels.size() != 0)
            @(negedge clk);
    endtask

    // Level receiver: random stalls per word, one long hold-off on request.
    initial
    begin : level_sink
        int stall;

        level_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                stall = HOLD_CYCLES;
            end
            else
            begin
                stall = no_idle ? 0 : $urandom_range(0, 8);
            end
            @(negedge clk);
            if (stall > 0)
            begin
                level_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            level_ready <= 1'b1;
            @(posedge clk);
            while (!level_valid)
                @(posedge clk);
            check_level(level);
        end
    end

    // Ends the run if no word moves on either side for too long.
    initial
    begin : watchdog
        int quiet_cycles;

        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (sample_valid && sample_ready) || (level_valid && level_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Watchdog: no word moved for %0d cycles", STALL_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    // Reset, directed table, random phases under changing clamp limits.
    initial
    begin : stimulus
        int                 row;
        int                 phase;
        int                 word;
        logic [CLAMP_W-1:0] clamp;

        rst_n          = 1'b0;
        sample_valid   = 1'b0;
        sample         = '0;
        cfg_we         = 1'b0;
        cfg_wdata      = '0;
        no_idle        = 1'b0;
        hold_request   = 1'b0;
        run_left       = 0;
        run_value      = '0;
        samples_sent   = 0;
        levels_checked = 0;
        full_words     = 0;
        mismatch_count = 0;

        // The sample ring and both sums come out of reset cleared.
        foreach (raw_ring[i])
            raw_ring[i] = '0;
        raw_sum     = '0;
        raw_head    = 0;
        mean_sum    = '0;
        mean_head   = 0;
        mean_fill   = 0;
        clamp_limit = CLAMP_RESET;

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        for (row = 0; row < DIRECTED_N; row++)
            send_word(directed_rows[row].value, directed_rows[row].typed,
                      directed_rows[row].want);

        for (phase = 0; phase < PHASE_N; phase++)
        begin
            // The clamp limit changes only while no word is in flight.
            drain_levels();
            clamp = (phase == RANDOM_CLAMP_PHASE) ? CLAMP_W'($urandom_range(20000, 80000))
                                                  : PHASE_CLAMPS[phase];
            @(negedge clk);
            cfg_we    <= 1'b1;
            cfg_wdata <= clamp;
            @(negedge clk);
            cfg_we <= 1'b0;
            clamp_limit = clamp;
            no_idle = PHASE_IDLE_FREE[phase];

            for (word = 0; word < PHASE_WORDS; word++)
            begin
                if (phase == PAUSE_PHASE && word == MID_WORD)
                    drain_levels();
                if (phase == HOLD_PHASE && word == MID_WORD)
                    hold_request = 1'b1;
                send_word(draw_sample(), 1'b0, '0);
            end
        end

        drain_levels();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d sample words and %0d level words under %0d clamp settings.",
                 samples_sent, levels_checked, PHASE_N + 1);
        $display("%0d level words came from a full smoothing window; %0d mismatches.",
                 full_words, mismatch_count);
        if (mismatch_count == 0 && expected_levels.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
